### hw/rtl/ebed_pkg.sv
// Shared types and constants for the encoder / button event decoder.
// Used by ebed_logic and encoder_button_event_decoder; no dependencies.
package ebed_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_MS     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTROLS_DISABLED = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOUND_ENABLE      = 2'd2;

    localparam logic [15:0] LONG_PRESS_MS_RST = 16'd1000;

    // Item kinds
    localparam logic KIND_ENCODER = 1'b0;
    localparam logic KIND_POLL    = 1'b1;

    // Micro-step count limits and click size
    localparam logic signed [7:0] STEP_MAX    = 8'sd124;
    localparam logic signed [7:0] STEP_MIN    = -8'sd124;
    localparam logic signed [7:0] CLICK_STEPS = 8'sd4;
    localparam logic signed [7:0] CLICK_POS   = 8'sd3;
    localparam logic signed [7:0] CLICK_NEG   = -8'sd3;

    typedef struct packed {
        logic        kind;
        logic        phase_a;
        logic        phase_b;
        logic        button_pressed;
        logic        cover_is_closed;
        logic        tank_present;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic        controls_disabled;
        logic        sound_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        last_code;
        logic signed [7:0] step_count;
        logic              cover_state;
        logic              tank_state;
        logic              press_active;
        logic              long_active;
        logic [31:0]       press_start;
    } state_t;

    typedef struct packed {
        logic ev_cover_closed;
        logic ev_cover_opened;
        logic ev_tank_inserted;
        logic ev_tank_removed;
        logic ev_long_press;
        logic ev_short_press;
        logic ev_up;
        logic ev_down;
        logic beep_request;
    } events_t;

    // Next code going forward in the Gray sequence 0,2,3,1
    function automatic logic [1:0] gray_next(input logic [1:0] code);
        logic [1:0] nxt;
        unique case (code)
            2'd0:    nxt = 2'd2;
            2'd1:    nxt = 2'd0;
            2'd2:    nxt = 2'd3;
            2'd3:    nxt = 2'd1;
            default: nxt = 2'd0;
        endcase
        return nxt;
    endfunction

endpackage

### hw/rtl/ebed_logic.sv
// Next-state and event logic for one item of the encoder / button decoder.
// Depends on ebed_pkg.
module ebed_logic (
    input  ebed_pkg::item_t   item,
    input  ebed_pkg::cfg_t    cfg,
    input  ebed_pkg::state_t  st,
    output ebed_pkg::state_t  st_next,
    output ebed_pkg::events_t ev
);
    import ebed_pkg::*;

    logic [1:0]  code;
    logic        step_up;
    logic        step_down;
    logic [31:0] held_ms;

    assign code      = {item.phase_b, item.phase_a};
    assign step_up   = (code != st.last_code) && (gray_next(st.last_code) == code);
    assign step_down = (code != st.last_code) && !step_up
                       && (gray_next(code) == st.last_code);
    assign held_ms   = item.now_ms - st.press_start;

    always_comb
    begin
        st_next = st;
        ev      = '0;
        if (item.kind == KIND_ENCODER)
        begin
            st_next.last_code = code;
            if (step_up && (st.step_count != STEP_MAX))
            begin
                st_next.step_count = st.step_count + 8'sd1;
            end
            else if (step_down && (st.step_count != STEP_MIN))
            begin
                st_next.step_count = st.step_count - 8'sd1;
            end
        end
        else if (!cfg.controls_disabled)
        begin
            if (item.cover_is_closed != st.cover_state)
            begin
                ev.ev_cover_closed  = item.cover_is_closed;
                ev.ev_cover_opened  = !item.cover_is_closed;
                st_next.cover_state = item.cover_is_closed;
            end
            if (item.tank_present != st.tank_state)
            begin
                ev.ev_tank_inserted = item.tank_present;
                ev.ev_tank_removed  = !item.tank_present;
                st_next.tank_state  = item.tank_present;
            end
            if (item.button_pressed)
            begin
                if (!st.press_active)
                begin
                    st_next.press_active = 1'b1;
                    st_next.press_start  = item.now_ms;
                end
                else if (!st.long_active && (held_ms > {16'd0, cfg.long_press_ms}))
                begin
                    st_next.long_active = 1'b1;
                    ev.ev_long_press    = 1'b1;
                end
            end
            else if (st.press_active)
            begin
                ev.ev_short_press    = !st.long_active;
                st_next.long_active  = 1'b0;
                st_next.press_active = 1'b0;
            end
            // at most one click per poll
            if (st.step_count > CLICK_POS)
            begin
                st_next.step_count = st.step_count - CLICK_STEPS;
                ev.ev_up           = 1'b1;
            end
            else if (st.step_count < CLICK_NEG)
            begin
                st_next.step_count = st.step_count + CLICK_STEPS;
                ev.ev_down         = 1'b1;
            end
            ev.beep_request = cfg.sound_enable
                              && (ev.ev_long_press || ev.ev_short_press
                                  || ev.ev_up || ev.ev_down);
        end
    end

endmodule

### hw/rtl/encoder_button_event_decoder.sv
// Top level of the encoder / button event decoder: channel registers,
// decoder state and configuration registers. Depends on ebed_pkg, ebed_logic.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per accepted cycle:
//   kind 0 is a quadrature pin sample, kind 1 a control poll with button,
//   cover, tank levels and a millisecond time stamp.
//   Output channel (out_valid / out_stall) returns exactly one result item
//   per input item, in order: nine event flags (all zero for pin samples).
//   Path: an accepted item goes to the input register, its result to the
//   result register. Throughput: one item per cycle while out_stall is low,
//   set by the single decoder state update between these two registers.
//   Stall: when the receiver holds out_stall, the result register keeps its
//   item, the input register may still fill once, and in_stall rises when
//   both are occupied; it clears in the same cycle the result is taken.
//   Configuration: cfg_write with cfg_index / cfg_data writes one register
//   (0 long_press_ms, 1 controls_disabled, 2 sound_enable); other indexes
//   are ignored. Write only while no item is in flight.
//   Reset (rst_n low, async): both channel stages empty, count zero, cover
//   open, tank removed, no press; long_press_ms 1000, sound on.
module encoder_button_event_decoder (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_write,
    input  logic [ebed_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ebed_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             kind,
    input  logic                             phase_a,
    input  logic                             phase_b,
    input  logic                             button_pressed,
    input  logic                             cover_is_closed,
    input  logic                             tank_present,
    input  logic [31:0]                      now_ms,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             ev_cover_closed,
    output logic                             ev_cover_opened,
    output logic                             ev_tank_inserted,
    output logic                             ev_tank_removed,
    output logic                             ev_long_press,
    output logic                             ev_short_press,
    output logic                             ev_up,
    output logic                             ev_down,
    output logic                             beep_request
);
    import ebed_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    item_t   item_reg;
    logic    item_valid_reg;
    events_t ev_reg;
    events_t ev_next;
    logic    out_valid_reg;

    logic    out_free;   // result register can take a new item
    logic    item_move;  // input register item goes through the logic this cycle
    logic    in_take;

    assign out_free  = !out_valid_reg || !out_stall;
    assign item_move = item_valid_reg && out_free;
    assign in_stall  = item_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    ebed_logic u_logic (
        .item    (item_reg),
        .cfg     (cfg_reg),
        .st      (state_reg),
        .st_next (state_next),
        .ev      (ev_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ms     <= LONG_PRESS_MS_RST;
            cfg_reg.controls_disabled <= 1'b0;
            cfg_reg.sound_enable      <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_LONG_PRESS_MS:     cfg_reg.long_press_ms     <= cfg_data;
                CFG_CONTROLS_DISABLED: cfg_reg.controls_disabled <= cfg_data[0];
                CFG_SOUND_ENABLE:      cfg_reg.sound_enable      <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (item_move)
        begin
            state_reg <= state_next;
        end
    end

    // channel control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (item_move)
            begin
                item_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= item_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.kind            <= kind;
            item_reg.phase_a         <= phase_a;
            item_reg.phase_b         <= phase_b;
            item_reg.button_pressed  <= button_pressed;
            item_reg.cover_is_closed <= cover_is_closed;
            item_reg.tank_present    <= tank_present;
            item_reg.now_ms          <= now_ms;
        end
        if (item_move)
        begin
            ev_reg <= ev_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign ev_cover_closed  = ev_reg.ev_cover_closed;
    assign ev_cover_opened  = ev_reg.ev_cover_opened;
    assign ev_tank_inserted = ev_reg.ev_tank_inserted;
    assign ev_tank_removed  = ev_reg.ev_tank_removed;
    assign ev_long_press    = ev_reg.ev_long_press;
    assign ev_short_press   = ev_reg.ev_short_press;
    assign ev_up            = ev_reg.ev_up;
    assign ev_down          = ev_reg.ev_down;
    assign beep_request     = ev_reg.beep_request;

endmodule
